/* hw/rtl/insertion_sorter_defines.svh */
// Assertion macros shared by the insertion sorter RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef INSERTION_SORTER_DEFINES_SVH
`define INSERTION_SORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ISORT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ISORT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/isort_pkg.sv */
// Package for the insertion sorter: word width and sequencer state type.
// No dependencies; imported by the store and the top level.
package isort_pkg;

  localparam int WORD_W = 32;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PLACE,
    S_EMIT_RD,
    S_EMIT_LD
  } isort_state_t;

endpackage

/* hw/rtl/isort_ram.sv */
// Value store of the insertion sorter: one write port, one read port, registered read.
// Depends on isort_pkg for the word width.
module isort_ram
  import isort_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/insertion_sorter.sv */
// Insertion sorter: a value arriving at an empty store is written directly and one arriving at a full
// store is dropped; otherwise each stored entry greater than it moves up one slot, then it fills the hole.
// Each emitted result is a store read, then an output register load that waits while that register is occupied.
// The insertion walk advances one entry per cycle through the single store read port.
// Reset (rst_n low, synchronous) clears the entry count, the overflow flag and the
// output valid; store contents stay undefined and are never read before being written.
//
// Depends on isort_pkg, isort_ram and insertion_sorter_defines.svh.
`include "insertion_sorter_defines.svh"

module insertion_sorter
  import isort_pkg::*;
#(
  parameter int CAPACITY = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [WORD_W-1:0] in_value,
  input  logic                     in_last_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [WORD_W-1:0] out_sorted_value,
  output logic                     out_end_of_run,
  output logic                     out_overflowed
);

  // AW addresses one entry; CW holds counts from zero up to CAPACITY itself.
  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  isort_state_t state_r, state_nxt;

  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  logic [AW-1:0]     k_r, k_nxt;
  logic [WORD_W-1:0] val_r, val_nxt;
  logic              last_r, last_nxt;

  logic                     out_valid_r;
  logic signed [WORD_W-1:0] out_value_r;
  logic                     out_end_r;
  logic                     out_ovf_r;

  // Store port controls.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic          in_accept;
  logic          out_free;
  logic          out_load;
  logic          store_full;
  logic [CW-1:0] cnt_m1;
  logic          last_k;
  logic          neighbor_gt;

  isort_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign in_accept  = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign store_full = (count_r == CW'(CAPACITY));
  assign cnt_m1     = count_r - CW'(1);
  assign last_k     = (CW'(k_r) == cnt_m1);

  // The one shared compare unit: is the stored neighbor strictly greater than the
  // value being inserted? Equal values stop the walk, so arrival order is kept.
  assign neighbor_gt = $signed(ram_rdata) > $signed(val_r);

  // Sequencer. An insertion reads the entry just below the current hole every
  // cycle; while that neighbor is greater it moves up into the hole and the next
  // read is issued in the same cycle, so the walk advances one entry per cycle.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    pos_nxt   = pos_r;
    k_nxt     = k_r;
    val_nxt   = val_r;
    last_nxt  = last_r;
    ram_we    = 1'b0;
    ram_waddr = pos_r;
    ram_wdata = val_r;
    ram_re    = 1'b0;
    ram_raddr = k_r;
    out_load  = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          val_nxt  = in_value;
          last_nxt = in_last_item;
          k_nxt    = '0;
          if (store_full) begin
            // The value is dropped; the run remembers it.
            ovf_nxt   = 1'b1;
            state_nxt = in_last_item ? S_EMIT_RD : S_IDLE;
          end else if (count_r == '0) begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_value;
            count_nxt = count_r + CW'(1);
            state_nxt = in_last_item ? S_EMIT_RD : S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = cnt_m1[AW-1:0];
            pos_nxt   = count_r[AW-1:0];
            state_nxt = S_CMP;
          end
        end
      end

      S_CMP: begin
        ram_waddr = pos_r;
        if (neighbor_gt) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata;
          pos_nxt   = pos_r - AW'(1);
          if (pos_r > AW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = pos_r - AW'(1) - AW'(1);
          end else begin
            state_nxt = S_PLACE;
          end
        end else begin
          ram_we    = 1'b1;
          ram_wdata = val_r;
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? S_EMIT_RD : S_IDLE;
        end
      end

      S_PLACE: begin
        // Every stored entry was greater: the value goes to the bottom.
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = val_r;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? S_EMIT_RD : S_IDLE;
      end

      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = k_r;
        state_nxt = S_EMIT_LD;
      end

      S_EMIT_LD: begin
        // Read data holds while the output register is still occupied.
        if (out_free) begin
          out_load = 1'b1;
          if (last_k) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      pos_r   <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      pos_r   <= pos_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  // Output register: a finished result waits here while the sequencer returns to
  // idle and accepts the next input transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r <= $signed(ram_rdata);
      out_end_r   <= last_k;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_end_of_run   = out_end_r;
  assign out_overflowed   = out_ovf_r;

  `ISORT_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "entry count above capacity")
  `ISORT_ASSERT_IMPL(a_cmp_hole, clk, rst_n, state_r == S_CMP, pos_r != '0, "insertion walk with hole at bottom")
  `ISORT_ASSERT_IMPL(a_emit_nonempty, clk, rst_n, state_r == S_EMIT_RD, count_r != '0, "emission from an empty run")
  `ISORT_ASSERT_NEXT(a_run_cleared, clk, rst_n, out_load && last_k, (count_r == '0) && !ovf_r && (state_r == S_IDLE), "run not cleared after its final result")
  `ISORT_ASSERT_IMPL(a_load_free, clk, rst_n, out_load, !out_valid_r || out_ready, "output register overwritten while occupied")

endmodule
